>>> hw/rtl/grid_wave_equation_step_core_defines.svh
// Assertion helpers for the wave step core.
`ifndef GRID_WAVE_EQUATION_STEP_CORE_DEFINES_SVH
`define GRID_WAVE_EQUATION_STEP_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GWES_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GWES_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gwes_pkg.sv
package gwes_pkg;

  // default geometry and store width
  localparam int GRID_ROWS_DEF    = 8;
  localparam int GRID_COLUMNS_DEF = 6;
  localparam int HEIGHT_WIDTH_DEF = 24;

  // port field widths
  localparam int ACTION_W  = 2;
  localparam int ROW_W     = 3;
  localparam int COL_W     = 3;
  localparam int FIELD_H_W = 24;
  localparam int COEF_W    = 16;
  localparam int TIME_W    = 16;
  localparam int SCALE_W   = 20;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;

  // item kinds
  localparam logic [ACTION_W-1:0] ACT_STEP     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WR_CUR   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_WR_PREV  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ     = 2'd3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_SCALE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIME_INCR  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_LIMIT = 2'd2;

  localparam logic [SCALE_W-1:0] COEF_SCALE_RST = 20'd655;
  localparam logic [TIME_W-1:0]  TIME_INCR_RST  = 16'd102;
  localparam logic [COEF_W-1:0]  COEF_LIMIT_RST = 16'd32768;

  // initial heights, Q8.16: -0.01 everywhere, 0.2 at the peak cell
  localparam longint RST_HEIGHT = -655;
  localparam longint RST_PEAK   = 13107;

  function automatic longint sat_height(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -(longint'(1) <<< (w - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

>>> hw/rtl/grid_wave_equation_step_core.sv
// Wave equation step core. Current and previous height grids (GRID_ROWS x
// GRID_COLUMNS signed Q8.16 cells) sit in two single-port-write RAMs whose
// roles swap at the end of every step. A step item first forms the
// coefficient in the TIME, SQR and COEF states; then the current grid
// streams out of its RAM one cell per cycle into a two-row line buffer
// while new heights are written over the previous grid behind it. After
// reset the core loads the start heights and takes no item meanwhile;
// configuration writes are taken throughout and must only be issued
// while the core is idle.
`include "grid_wave_equation_step_core_defines.svh"

module grid_wave_equation_step_core #(
  parameter int GRID_ROWS    = gwes_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLUMNS = gwes_pkg::GRID_COLUMNS_DEF,
  parameter int HEIGHT_WIDTH = gwes_pkg::HEIGHT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // row[2:0], column[5:3], height_value[29:6], zero pad
  input  logic [gwes_pkg::IN_DATA_W-1:0]      in_tdata,
  // action[1:0]
  input  logic [gwes_pkg::ACTION_W-1:0]       in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // current_height[23:0], previous_height[47:24], coefficient_used[63:48],
  // saturated[64], zero pad
  output logic [gwes_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [gwes_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [gwes_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int H   = HEIGHT_WIDTH;
  localparam int C   = GRID_COLUMNS;
  localparam int R   = GRID_ROWS;
  localparam int N   = R * C;
  localparam int AW  = $clog2(N);
  localparam int RW  = $clog2(R);
  localparam int CW  = $clog2(C);
  localparam int TW  = $clog2(N + C + 3);
  localparam int FW  = gwes_pkg::FIELD_H_W;
  localparam int VW  = (H > FW) ? H : FW;
  localparam int LW  = H + 3;
  localparam int BW  = H + 2;
  localparam int PW  = LW + gwes_pkg::COEF_W + 1;
  localparam int SW  = PW + 1;
  localparam int CENTER = (R / 2) * C + C / 2;

  localparam logic signed [H-1:0] RST_LOW_H  =
    H'(gwes_pkg::sat_height(gwes_pkg::RST_HEIGHT, H));
  localparam logic signed [H-1:0] RST_PEAK_H =
    H'(gwes_pkg::sat_height(gwes_pkg::RST_PEAK, H));

  localparam logic signed [SW-1:0] HMAX_S = {{(SW-H+1){1'b0}}, {(H-1){1'b1}}};
  localparam logic signed [SW-1:0] HMIN_S = {{(SW-H+1){1'b1}}, {(H-1){1'b0}}};
  localparam logic signed [VW-1:0] HMAX_V = {{(VW-H+1){1'b0}}, {(H-1){1'b1}}};
  localparam logic signed [VW-1:0] HMIN_V = {{(VW-H+1){1'b1}}, {(H-1){1'b0}}};

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_TIME = 3'd3;
  localparam logic [2:0] ST_SQR  = 3'd4;
  localparam logic [2:0] ST_COEF = 3'd5;
  localparam logic [2:0] ST_RUN  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;

  // configuration
  logic [gwes_pkg::SCALE_W-1:0] coef_scale_r;
  logic [gwes_pkg::TIME_W-1:0]  time_incr_r;
  logic [gwes_pkg::COEF_W-1:0]  coef_limit_r;

  // step control
  logic [gwes_pkg::TIME_W-1:0]  elapsed_r;
  logic [2*gwes_pkg::TIME_W-1:0] tt_r;
  logic [gwes_pkg::COEF_W-1:0]  coef_r;
  logic                         sat_r;
  logic                         sel_r;     // 0: RAM A holds the current grid
  logic [AW-1:0]                init_cnt_r;
  logic [TW-1:0]                t_r;
  logic [AW-1:0]                k_cnt_r;
  logic [RW-1:0]                k_row_r;
  logic [CW-1:0]                k_col_r;

  // item
  logic [gwes_pkg::ACTION_W-1:0] act_r;
  logic                          inside_r;
  logic [FW-1:0]                 res_cur_r;
  logic [FW-1:0]                 res_prev_r;

  // output word
  logic                              out_tvalid_r;
  logic [gwes_pkg::OUT_DATA_W-1:0]   out_tdata_r;

  // height RAMs
  logic [H-1:0] mem_a [N];
  logic [H-1:0] mem_b [N];
  logic [H-1:0] rd_a_r, rd_b_r;
  logic         a_we, b_we;
  logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [H-1:0] a_wdata, b_wdata;

  logic          cur_we, prev_we;
  logic [AW-1:0] cur_waddr, prev_waddr, cur_raddr, prev_raddr;
  logic [H-1:0]  cur_wdata, prev_wdata;

  // update pipeline
  logic signed [H-1:0] line_r [2*C];
  logic                d1_v_r, s1_v_r, s2_v_r;
  logic [AW-1:0]       d1_k_r, s1_k_r, s2_k_r;
  logic                d1_int_r, s1_int_r, s2_int_r;
  logic signed [LW-1:0] s1_lap_r;
  logic signed [BW-1:0] s1_base_r, s2_base_r;
  logic signed [PW-1:0] s2_prod_r;

  // input decode
  logic [gwes_pkg::ROW_W-1:0] in_row;
  logic [gwes_pkg::COL_W-1:0] in_col;
  logic signed [FW-1:0]       in_val;
  logic signed [VW-1:0]       in_val_ext;
  logic [H-1:0]               in_val_sat;
  logic                       in_inside;
  logic [AW-1:0]              in_idx;
  logic                       accept;

  logic signed [H-1:0]  cur_q, prev_q;
  logic signed [VW-1:0] cur_ext, prev_ext;
  logic signed [LW-1:0] lap;
  logic signed [BW-1:0] base;
  logic signed [SW-1:0] upd;
  logic                 upd_hi, upd_lo;
  logic [H-1:0]         upd_sat;
  logic                 issue_k;
  logic                 run_end;
  logic [gwes_pkg::TIME_W:0]     time_sum;
  logic [51:0]                   scale_tt;
  logic [31:0]                   coef_full;

  assign in_row     = in_tdata[2:0];
  assign in_col     = in_tdata[5:3];
  assign in_val     = $signed(in_tdata[29:6]);
  assign in_val_ext = VW'(in_val);
  assign in_val_sat = (in_val_ext > HMAX_V) ? HMAX_V[H-1:0] :
                      (in_val_ext < HMIN_V) ? HMIN_V[H-1:0] : in_val_ext[H-1:0];
  assign in_inside  = (32'(in_row) < 32'(R)) && (32'(in_col) < 32'(C));
  assign in_idx     = in_inside ? AW'(32'(in_row) * 32'(C) + 32'(in_col)) : '0;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign cur_q    = $signed(sel_r ? rd_b_r : rd_a_r);
  assign prev_q   = $signed(sel_r ? rd_a_r : rd_b_r);
  assign cur_ext  = VW'(cur_q);
  assign prev_ext = VW'(prev_q);

  assign issue_k = (state_r == ST_RUN) && (t_r >= TW'(C)) && (t_r < TW'(N + C));
  assign run_end = (t_r == TW'(N + C + 2));

  assign time_sum  = {1'b0, elapsed_r} + {1'b0, time_incr_r};
  assign scale_tt  = coef_scale_r * tt_r;
  assign coef_full = scale_tt[51:20];

  // window around cell t-C-1: bottom arrives from RAM, the rest from the line
  assign lap = LW'(line_r[C]) + LW'(line_r[C-2]) + LW'(line_r[2*C-1]) + LW'(cur_q)
             - (LW'(line_r[C-1]) <<< 2);
  assign base = BW'(line_r[C-1]) + BW'(line_r[C-1]) - BW'(prev_q);

  // floor shift of the product comes free with the arithmetic shift
  assign upd     = SW'(s2_base_r) + SW'(s2_prod_r >>> 16);
  assign upd_hi  = upd > HMAX_S;
  assign upd_lo  = upd < HMIN_S;
  assign upd_sat = upd_hi ? HMAX_S[H-1:0] : upd_lo ? HMIN_S[H-1:0] : upd[H-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: if (init_cnt_r == AW'(N - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            gwes_pkg::ACT_STEP: state_nxt = ST_TIME;
            gwes_pkg::ACT_READ: state_nxt = ST_READ;
            default:            state_nxt = ST_FIN;
          endcase
        end
      end
      ST_READ: state_nxt = ST_FIN;
      ST_TIME: state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_COEF;
      ST_COEF: state_nxt = ST_RUN;
      ST_RUN:  if (run_end) state_nxt = ST_FIN;
      ST_FIN:  if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // logical ports: current / previous grid
  always_comb begin
    cur_we     = 1'b0;
    cur_waddr  = init_cnt_r;
    cur_wdata  = (init_cnt_r == AW'(CENTER)) ? RST_PEAK_H : RST_LOW_H;
    prev_we    = 1'b0;
    prev_waddr = init_cnt_r;
    prev_wdata = RST_LOW_H;
    cur_raddr  = (t_r < TW'(N)) ? t_r[AW-1:0] : '0;
    prev_raddr = k_cnt_r;
    unique case (state_r)
      ST_INIT: begin
        cur_we  = 1'b1;
        prev_we = 1'b1;
      end
      ST_IDLE: begin
        cur_raddr  = in_idx;
        prev_raddr = in_idx;
        cur_waddr  = in_idx;
        prev_waddr = in_idx;
        cur_wdata  = in_val_sat;
        prev_wdata = in_val_sat;
        cur_we  = accept && in_inside && (in_tuser == gwes_pkg::ACT_WR_CUR);
        prev_we = accept && in_inside && (in_tuser == gwes_pkg::ACT_WR_PREV);
      end
      default: begin
        // new heights land over the previous grid behind the read front
        prev_we    = s2_v_r;
        prev_waddr = s2_k_r;
        prev_wdata = s2_int_r ? upd_sat : '0;
      end
    endcase
  end

  assign a_we    = sel_r ? prev_we    : cur_we;
  assign a_waddr = sel_r ? prev_waddr : cur_waddr;
  assign a_wdata = sel_r ? prev_wdata : cur_wdata;
  assign a_raddr = sel_r ? prev_raddr : cur_raddr;
  assign b_we    = sel_r ? cur_we     : prev_we;
  assign b_waddr = sel_r ? cur_waddr  : prev_waddr;
  assign b_wdata = sel_r ? cur_wdata  : prev_wdata;
  assign b_raddr = sel_r ? cur_raddr  : prev_raddr;

  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    rd_a_r <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[b_waddr] <= b_wdata;
    rd_b_r <= mem_b[b_raddr];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_scale_r <= gwes_pkg::COEF_SCALE_RST;
      time_incr_r  <= gwes_pkg::TIME_INCR_RST;
      coef_limit_r <= gwes_pkg::COEF_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gwes_pkg::REG_COEF_SCALE: coef_scale_r <= cfg_wdata;
        gwes_pkg::REG_TIME_INCR:  time_incr_r  <= cfg_wdata[gwes_pkg::TIME_W-1:0];
        gwes_pkg::REG_COEF_LIMIT: coef_limit_r <= cfg_wdata[gwes_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      init_cnt_r   <= '0;
      sel_r        <= 1'b0;
      elapsed_r    <= '0;
      out_tvalid_r <= 1'b0;
      d1_v_r       <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      d1_v_r  <= issue_k;
      s1_v_r  <= d1_v_r;
      s2_v_r  <= s1_v_r;
      if (state_r == ST_INIT) init_cnt_r <= init_cnt_r + AW'(1);
      if (state_r == ST_TIME) begin
        elapsed_r <= time_sum[gwes_pkg::TIME_W] ? '1 : time_sum[gwes_pkg::TIME_W-1:0];
      end
      if (state_r == ST_RUN && run_end) sel_r <= ~sel_r;
      if (state_r == ST_FIN && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_tuser;
      inside_r <= in_inside;
    end
    if (state_r == ST_READ) begin
      res_cur_r  <= inside_r ? cur_ext[FW-1:0]  : '0;
      res_prev_r <= inside_r ? prev_ext[FW-1:0] : '0;
    end
    if (state_r == ST_SQR) tt_r <= elapsed_r * elapsed_r;
    if (state_r == ST_COEF) begin
      coef_r  <= (coef_full > 32'(coef_limit_r)) ? coef_limit_r
                                                 : coef_full[gwes_pkg::COEF_W-1:0];
      sat_r   <= 1'b0;
      t_r     <= '0;
      k_cnt_r <= '0;
      k_row_r <= '0;
      k_col_r <= '0;
    end
    if (state_r == ST_RUN) begin
      t_r <= t_r + TW'(1);
      line_r[0] <= cur_q;
      for (int i = 1; i < 2 * C; i++) line_r[i] <= line_r[i-1];
    end
    if (issue_k) begin
      k_cnt_r <= k_cnt_r + AW'(1);
      if (k_col_r == CW'(C - 1)) begin
        k_col_r <= '0;
        k_row_r <= k_row_r + RW'(1);
      end else begin
        k_col_r <= k_col_r + CW'(1);
      end
    end
    d1_k_r   <= k_cnt_r;
    d1_int_r <= (k_row_r != '0) && (k_row_r != RW'(R - 1)) &&
                (k_col_r != '0) && (k_col_r != CW'(C - 1));
    s1_k_r    <= d1_k_r;
    s1_int_r  <= d1_int_r;
    s1_lap_r  <= lap;
    s1_base_r <= base;
    s2_k_r    <= s1_k_r;
    s2_int_r  <= s1_int_r;
    s2_base_r <= s1_base_r;
    s2_prod_r <= $signed({1'b0, coef_r}) * s1_lap_r;
    if (s2_v_r && s2_int_r && (upd_hi || upd_lo)) sat_r <= 1'b1;
    if (state_r == ST_FIN && (!out_tvalid_r || out_tready)) begin
      case (act_r)
        gwes_pkg::ACT_STEP:
          out_tdata_r <= {7'd0, sat_r, coef_r, {(2*FW){1'b0}}};
        gwes_pkg::ACT_READ:
          out_tdata_r <= {7'd0, 1'b0, {gwes_pkg::COEF_W{1'b0}}, res_prev_r, res_cur_r};
        default:
          out_tdata_r <= '0;
      endcase
    end
  end

  `GWES_ASSERT_SAME(a_pipe_drained, (state_r == ST_IDLE) || (state_r == ST_FIN), !d1_v_r && !s1_v_r && !s2_v_r, "update pipeline busy outside a step")
  `GWES_ASSERT_NEXT(a_bank_swap, (state_r == ST_RUN) && (state_nxt == ST_FIN), sel_r != $past(sel_r), "grid roles not swapped at step end")
  `GWES_ASSERT_SAME(a_coef_clamped, state_r == ST_RUN, coef_r <= coef_limit_r, "coefficient above limit")
  `GWES_ASSERT_SAME(a_update_in_step, s2_v_r, state_r == ST_RUN, "grid update outside a step")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int ROWS  = gwes_pkg::GRID_ROWS_DEF;
  localparam int COLS  = gwes_pkg::GRID_COLUMNS_DEF;
  localparam int CELLS = ROWS * COLS;
  localparam longint H_HI = (longint'(1) <<< (gwes_pkg::HEIGHT_WIDTH_DEF - 1)) - 1;
  localparam longint H_LO = -(longint'(1) <<< (gwes_pkg::HEIGHT_WIDTH_DEF - 1));
  localparam logic [gwes_pkg::CFG_ADDR_W-1:0] REG_NONE = 2'd3;
  localparam logic [23:0] H_MAX_W = 24'h7FFFFF;
  localparam logic [23:0] H_MIN_W = 24'h800000;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 50;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 156;

  typedef struct packed {
    logic [gwes_pkg::ACTION_W-1:0] action;
    logic [gwes_pkg::ROW_W-1:0]    row;
    logic [gwes_pkg::COL_W-1:0]    col;
    logic [23:0]                   height;
  } wave_op_t;

  typedef struct packed {
    logic [23:0]                 cur;
    logic [23:0]                 prev;
    logic [gwes_pkg::COEF_W-1:0] coef;
    logic                        sat;
  } cell_readout_t;

  typedef struct packed {
    wave_op_t      op;
    logic          typed;
    cell_readout_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [gwes_pkg::IN_DATA_W-1:0] in_tdata;
  logic [gwes_pkg::ACTION_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [gwes_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_we;
  logic [gwes_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [gwes_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // model state
  logic signed [23:0] cur_h [CELLS];
  logic signed [23:0] prev_h [CELLS];
  logic [gwes_pkg::TIME_W-1:0]  t_elapsed;
  logic [gwes_pkg::SCALE_W-1:0] scale_r;
  logic [gwes_pkg::TIME_W-1:0]  incr_r;
  logic [gwes_pkg::COEF_W-1:0]  limit_r;

  cell_readout_t readout_q [$];
  dir_row_t dir_tab [$];
  int fail_count = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  grid_wave_equation_step_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void wave_reset();
    for (int k = 0; k < CELLS; k++) begin
      cur_h[k]  = 24'(gwes_pkg::RST_HEIGHT);
      prev_h[k] = 24'(gwes_pkg::RST_HEIGHT);
    end
    cur_h[(ROWS / 2) * COLS + COLS / 2] = 24'(gwes_pkg::RST_PEAK);
    t_elapsed = '0;
    scale_r   = gwes_pkg::COEF_SCALE_RST;
    incr_r    = gwes_pkg::TIME_INCR_RST;
    limit_r   = gwes_pkg::COEF_LIMIT_RST;
  endfunction

  // applies one word to the model grids and returns the readout it yields
  function automatic cell_readout_t wave_apply(wave_op_t op);
    cell_readout_t res;
    logic signed [23:0] nxt [CELLS];
    longint unsigned tsum;
    longint unsigned prod;
    longint coef;
    longint lap;
    longint v;
    int k;
    bit hit;
    bit on_grid;
    res = '0;
    hit = 1'b0;
    on_grid = (int'(op.row) < ROWS) && (int'(op.col) < COLS);
    k = int'(op.row) * COLS + int'(op.col);
    case (op.action)
      gwes_pkg::ACT_STEP: begin
        tsum = longint'(t_elapsed) + longint'(incr_r);
        if (tsum > 65535) tsum = 65535;
        t_elapsed = tsum[15:0];
        prod = (64'(scale_r) * tsum * tsum) >> 20;
        if (prod > limit_r) prod = limit_r;
        coef = longint'(prod);
        for (int j = 0; j < CELLS; j++) nxt[j] = '0;
        for (int r = 1; r < ROWS - 1; r++) begin
          for (int c = 1; c < COLS - 1; c++) begin
            k = r * COLS + c;
            lap = longint'(cur_h[k - 1]) + longint'(cur_h[k + 1])
                + longint'(cur_h[k - COLS]) + longint'(cur_h[k + COLS])
                - 4 * longint'(cur_h[k]);
            // arithmetic shift rounds toward minus infinity
            v = 2 * longint'(cur_h[k]) - longint'(prev_h[k]) + ((coef * lap) >>> 16);
            if (v > H_HI) begin
              v = H_HI;
              hit = 1'b1;
            end else if (v < H_LO) begin
              v = H_LO;
              hit = 1'b1;
            end
            nxt[k] = v[23:0];
          end
        end
        prev_h = cur_h;
        cur_h = nxt;
        res.coef = prod[15:0];
        res.sat = hit;
      end
      gwes_pkg::ACT_WR_CUR: begin
        if (on_grid) cur_h[k] = op.height;
      end
      gwes_pkg::ACT_WR_PREV: begin
        if (on_grid) prev_h[k] = op.height;
      end
      default: begin
        if (on_grid) begin
          res.cur = cur_h[k];
          res.prev = prev_h[k];
        end
      end
    endcase
    return res;
  endfunction

  function automatic dir_row_t dir_row(logic [gwes_pkg::ACTION_W-1:0] act, int r, int c,
                                       logic [23:0] h, bit typed,
                                       logic [23:0] cur, logic [23:0] prev);
    dir_row_t d;
    d.op.action = act;
    d.op.row = r[gwes_pkg::ROW_W-1:0];
    d.op.col = c[gwes_pkg::COL_W-1:0];
    d.op.height = h;
    d.typed = typed;
    d.res = '0;
    d.res.cur = cur;
    d.res.prev = prev;
    return d;
  endfunction

  function automatic logic [23:0] rand_height();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'(int'($urandom_range(0, 131071)) - 65536);
      2: return H_MAX_W;
      default: return H_MIN_W;
    endcase
  endfunction

  function automatic wave_op_t rand_op();
    wave_op_t op;
    int n;
    n = $urandom_range(0, 99);
    if (n < 15) op.action = gwes_pkg::ACT_STEP;
    else if (n < 45) op.action = gwes_pkg::ACT_WR_CUR;
    else if (n < 65) op.action = gwes_pkg::ACT_WR_PREV;
    else op.action = gwes_pkg::ACT_READ;
    op.row = 3'($urandom_range(0, 7));
    op.col = 3'($urandom_range(0, 7));
    op.height = rand_height();
    return op;
  endfunction

  // entered and left just after a rising edge
  task automatic send_word(wave_op_t op, bit typed, cell_readout_t fixed);
    int gap;
    cell_readout_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = op.action;
    in_tdata = {2'b00, op.height, op.col, op.row};
    do @(posedge clk); while (!in_tready);
    pred = wave_apply(op);
    readout_q.push_back(typed ? fixed : pred);
  endtask

  task automatic cfg_write(logic [gwes_pkg::CFG_ADDR_W-1:0] idx,
                           logic [gwes_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    case (idx)
      gwes_pkg::REG_COEF_SCALE: scale_r = val;
      gwes_pkg::REG_TIME_INCR:  incr_r = val[15:0];
      gwes_pkg::REG_COEF_LIMIT: limit_r = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_words();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stim
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = gwes_pkg::ACT_STEP;
    cfg_we = 1'b0;
    cfg_addr = gwes_pkg::REG_COEF_SCALE;
    cfg_wdata = '0;
    wave_reset();

    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 4, 3, 24'd0, 1, 24'd13107, -24'sd655));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 0, 0, 24'd0, 1, -24'sd655, -24'sd655));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 7, 5, 24'd0, 1, -24'sd655, -24'sd655));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 7, 7, 24'd0, 1, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 3, 6, 24'd0, 1, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_STEP, 0, 0, 24'd0, 0, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 4, 3, 24'd0, 0, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 4, 4, 24'd0, 0, 24'd0, 24'd0));
    // drive interior cells to both rails so the next step clamps
    dir_tab.push_back(dir_row(gwes_pkg::ACT_WR_CUR, 3, 3, H_MAX_W, 1, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_WR_PREV, 3, 3, H_MIN_W, 1, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_WR_CUR, 2, 2, H_MIN_W, 1, 24'd0, 24'd0));
    // off-grid writes are dropped; the writes to row 5, column 1 are on the grid and read back
    dir_tab.push_back(dir_row(gwes_pkg::ACT_WR_CUR, 7, 7, 24'h555555, 1, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_WR_PREV, 0, 6, 24'hAAAAAA, 1, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_WR_CUR, 5, 1, 24'h555555, 1, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_WR_PREV, 5, 1, 24'hAAAAAA, 1, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 3, 3, 24'd0, 1, H_MAX_W, H_MIN_W));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 5, 1, 24'd0, 1, 24'h555555, 24'hAAAAAA));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_STEP, 7, 7, 24'hFFFFFF, 0, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 3, 3, 24'd0, 0, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 2, 2, 24'd0, 0, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 0, 2, 24'd0, 0, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_WR_PREV, 7, 0, 24'd0, 1, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_STEP, 0, 0, 24'd0, 0, 24'd0, 24'd0));
    dir_tab.push_back(dir_row(gwes_pkg::ACT_READ, 6, 4, 24'd0, 0, 24'd0, 24'd0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_word(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].res);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_words();
      case (phase)
        0: begin
          cfg_write(gwes_pkg::REG_COEF_SCALE, 20'($urandom_range(0, 20'hFFFFF)));
          cfg_write(gwes_pkg::REG_TIME_INCR, 20'($urandom_range(1, 64)));
          cfg_write(gwes_pkg::REG_COEF_LIMIT, 20'($urandom_range(0, 20'hFFFFF)));
        end
        1: begin
          cfg_write(gwes_pkg::REG_COEF_SCALE, 20'd0);
          cfg_write(gwes_pkg::REG_TIME_INCR, 20'd0);
          cfg_write(gwes_pkg::REG_COEF_LIMIT, 20'd0);
          cfg_write(REG_NONE, 20'($urandom_range(0, 20'hFFFFF)));
        end
        2: begin
          cfg_write(gwes_pkg::REG_COEF_SCALE, 20'(gwes_pkg::COEF_SCALE_RST));
          cfg_write(gwes_pkg::REG_TIME_INCR, 20'(gwes_pkg::TIME_INCR_RST));
          cfg_write(gwes_pkg::REG_COEF_LIMIT, 20'(gwes_pkg::COEF_LIMIT_RST));
        end
        3: begin
          // elapsed time pins at its ceiling from here on
          cfg_write(gwes_pkg::REG_COEF_SCALE, 20'hFFFFF);
          cfg_write(gwes_pkg::REG_TIME_INCR, 20'hFFFFF);
          cfg_write(gwes_pkg::REG_COEF_LIMIT, 20'hFFFFF);
        end
        default: begin
          cfg_write(gwes_pkg::REG_COEF_SCALE, 20'($urandom_range(0, 20'hFFFFF)));
          cfg_write(gwes_pkg::REG_TIME_INCR, 20'($urandom_range(0, 20'hFFFFF)));
          cfg_write(gwes_pkg::REG_COEF_LIMIT, 20'($urandom_range(0, 20'hFFFFF)));
        end
      endcase
      @(negedge clk);
      cfg_we = 1'b0;
      @(posedge clk);
      no_idle = (phase == 2);
      repeat (PHASE_ITEMS) send_word(rand_op(), 1'b0, '0);
    end

    drain_words();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (readout_q.size() != 0) begin
      $error("%0d readouts never arrived", readout_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("grid_wave_equation_step_core: match");
    end else begin
      $display("grid_wave_equation_step_core: mismatch");
    end
    $finish;
  end

  initial begin : sink
    cell_readout_t got;
    cell_readout_t want;
    int stall;
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      // one long hold-off so the core backs up into its input
      if (!held && results_seen == HOLD_AT) begin
        stall = HOLD_CYCLES;
        held = 1'b1;
      end
      repeat (stall) begin
        @(negedge clk);
        out_tready = 1'b0;
        @(posedge clk);
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.cur  = out_tdata[23:0];
      got.prev = out_tdata[47:24];
      got.coef = out_tdata[63:48];
      got.sat  = out_tdata[64];
      results_seen++;
      if (readout_q.size() == 0) begin
        $error("readout with nothing pending: %h", out_tdata);
        fail_count++;
      end else begin
        want = readout_q.pop_front();
        if (got.cur !== want.cur) begin
          $error("current_height: expected %0d, got %0d",
                 $signed(want.cur), $signed(got.cur));
          fail_count++;
        end
        if (got.prev !== want.prev) begin
          $error("previous_height: expected %0d, got %0d",
                 $signed(want.prev), $signed(got.prev));
          fail_count++;
        end
        if (got.coef !== want.coef) begin
          $error("coefficient_used: expected %0d, got %0d", want.coef, got.coef);
          fail_count++;
        end
        if (got.sat !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, got.sat);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("grid_wave_equation_step_core: mismatch");
      $finish;
    end
  end

endmodule
